// File: rtl/vbid_pkg.sv
// Package for the voxel brick intra decoder.
// Holds the stream byte layout, color width and result status codes.
// No dependencies.
package vbid_pkg;

   localparam int BRICK_SIDE_DEF = 8;

   localparam int DATA_W         = 8;
   localparam int COLOR_W        = 8;
   localparam int STATUS_W       = 2;
   localparam int RUN_LEN_W      = 7;
   localparam int RUN_FILLED_BIT = 7;

   localparam logic [STATUS_W-1:0] ST_VOXEL    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] ST_CAPACITY = 2'd3;

endpackage

// File: rtl/voxel_brick_intra_decoder.sv
// Top level of the voxel brick intra decoder: run-length occupancy, then delta colors.
// Uses vbid_pkg, vbid_occ_mem and vbid_row_find.
//
// Usage: req_ carries one stream byte per item, rsp_ one result item, csr_ writes
// max_voxels (always ready, write only while the block is idle).
// A brick starts with run bytes (bit 7 filled, bits 6..0 length) that are written
// into a row-wide occupancy memory, one row per cycle. An accepted run byte is
// filled in row by row over every occupancy row that it touches.
// A run that overshoots the brick gives an overflow result at once. The run that
// closes the brick gives a capacity or empty result, or starts the color phase.
// The color phase scans the memory for the next filled voxel, row by row (read,
// then check). Each voxel then takes three color bytes; the third byte produces the
// voxel result and starts the next scan, unless it was the last voxel of the brick.
// Results go through one output register and appear the cycle after the byte is
// accepted. Run bytes and the third color byte wait while that register is full
// and rsp_ready is low; the first two color bytes are taken.
// Reset (synchronous) starts a new brick and sets max_voxels to the brick size.
// The memory needs no clearing: each brick writes every row before it is read.
module voxel_brick_intra_decoder #(
   parameter int BRICK_SIDE = vbid_pkg::BRICK_SIDE_DEF,
   localparam int BRICK_LEN = BRICK_SIDE * BRICK_SIDE * BRICK_SIDE,
   localparam int IDX_W     = $clog2(BRICK_LEN),
   localparam int CNT_W     = $clog2(BRICK_LEN + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [vbid_pkg::DATA_W-1:0]   req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [IDX_W-1:0]              rsp_voxel_index,
   output logic [vbid_pkg::COLOR_W-1:0]  rsp_red,
   output logic [vbid_pkg::COLOR_W-1:0]  rsp_green,
   output logic [vbid_pkg::COLOR_W-1:0]  rsp_blue,
   output logic [vbid_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_last_of_brick,
   output logic [CNT_W-1:0]              rsp_voxel_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CNT_W-1:0]              csr_max_voxels
);

   import vbid_pkg::*;

   localparam int ROWS   = BRICK_SIDE * BRICK_SIDE;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(BRICK_SIDE);
   localparam int POS_W  = $clog2(BRICK_LEN + (1 << RUN_LEN_W));
   localparam int SPAN_W = RUN_LEN_W + 1;

   localparam logic [2:0] S_RUN      = 3'd0;
   localparam logic [2:0] S_FILL     = 3'd1;
   localparam logic [2:0] S_SRCH_RD  = 3'd2;
   localparam logic [2:0] S_SRCH_CHK = 3'd3;
   localparam logic [2:0] S_COLOR    = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      max_voxels_ff, max_voxels_in;
   logic [CNT_W-1:0]      run_pos_ff, run_pos_in;
   logic [CNT_W-1:0]      filled_ff, filled_in;
   logic [CNT_W-1:0]      emitted_ff, emitted_in;
   logic [ROW_W-1:0]      fill_row_ff, fill_row_in;
   logic [COL_W-1:0]      fill_col_ff, fill_col_in;
   logic                  end_scan_ff, end_scan_in;
   logic [1:0]            cbyte_ff, cbyte_in;
   logic [COLOR_W-1:0]    prev_red_ff, prev_red_in;
   logic [COLOR_W-1:0]    prev_green_ff, prev_green_in;
   logic [COLOR_W-1:0]    prev_blue_ff, prev_blue_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [RUN_LEN_W-1:0]  rem_ff, rem_in;
   logic                  fill_bit_ff, fill_bit_in;
   logic [BRICK_SIDE-1:0] word_ff, word_in;
   logic [ROW_W-1:0]      srch_row_ff, srch_row_in;
   logic [COL_W-1:0]      srch_col_ff, srch_col_in;
   logic [IDX_W-1:0]      srch_base_ff, srch_base_in;
   logic [2*DATA_W-1:0]   pend_ff, pend_in;
   logic [IDX_W-1:0]      out_index_ff, out_index_in;
   logic [COLOR_W-1:0]    out_red_ff, out_red_in;
   logic [COLOR_W-1:0]    out_green_ff, out_green_in;
   logic [COLOR_W-1:0]    out_blue_ff, out_blue_in;
   logic [STATUS_W-1:0]   out_status_ff, out_status_in;
   logic                  out_last_ff, out_last_in;
   logic [CNT_W-1:0]      out_count_ff, out_count_in;

   logic                  out_free;
   logic                  accept;
   logic [RUN_LEN_W-1:0]  run_len;
   logic                  run_bit;
   logic [POS_W-1:0]      run_sum;
   logic [CNT_W-1:0]      filled_add;
   logic [SPAN_W-1:0]     space;
   logic [SPAN_W-1:0]     fill_hi;
   logic                  fill_wrap;
   logic [BRICK_SIDE-1:0] word_new;
   logic                  new_brick;
   logic [COLOR_W-1:0]    red_sum, green_sum, blue_sum;

   logic                  mem_wr_en;
   logic                  mem_rd_en;
   logic [BRICK_SIDE-1:0] mem_rd_data;
   logic                  find_found;
   logic [COL_W-1:0]      find_pos;

   vbid_occ_mem #(
      .WORD_W (BRICK_SIDE),
      .DEPTH  (ROWS)
   ) u_occ_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (fill_row_ff),
      .wr_data (word_new),
      .rd_en   (mem_rd_en),
      .rd_addr (srch_row_ff),
      .rd_data (mem_rd_data)
   );

   vbid_row_find #(
      .WIDTH (BRICK_SIDE)
   ) u_row_find (
      .word  (mem_rd_data),
      .from  (srch_col_ff),
      .found (find_found),
      .pos   (find_pos)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = ((state_ff == S_RUN) && out_free) ||
                      ((state_ff == S_COLOR) && ((cbyte_ff != 2'd2) || out_free));
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign run_len    = req_data_byte[RUN_LEN_W-1:0];
   assign run_bit    = req_data_byte[RUN_FILLED_BIT];
   assign run_sum    = POS_W'(run_pos_ff) + POS_W'(run_len);
   assign filled_add = filled_ff + (run_bit ? CNT_W'(run_len) : CNT_W'(0));

   assign space     = SPAN_W'(BRICK_SIDE) - SPAN_W'(fill_col_ff);
   assign fill_hi   = SPAN_W'(fill_col_ff) + SPAN_W'(rem_ff);
   assign fill_wrap = SPAN_W'(rem_ff) >= space;
   assign mem_wr_en = (state_ff == S_FILL) && fill_wrap;
   assign mem_rd_en = (state_ff == S_SRCH_RD);

   assign red_sum   = prev_red_ff + pend_ff[2*DATA_W-1:DATA_W];
   assign green_sum = prev_green_ff + pend_ff[DATA_W-1:0];
   assign blue_sum  = prev_blue_ff + req_data_byte;

   always_comb begin
      for (int i = 0; i < BRICK_SIDE; i++) begin
         if ((SPAN_W'(i) >= SPAN_W'(fill_col_ff)) && (SPAN_W'(i) < fill_hi)) begin
            word_new[i] = fill_bit_ff;
         end else begin
            word_new[i] = word_ff[i];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      max_voxels_in = max_voxels_ff;
      run_pos_in    = run_pos_ff;
      filled_in     = filled_ff;
      emitted_in    = emitted_ff;
      fill_row_in   = fill_row_ff;
      fill_col_in   = fill_col_ff;
      end_scan_in   = end_scan_ff;
      cbyte_in      = cbyte_ff;
      prev_red_in   = prev_red_ff;
      prev_green_in = prev_green_ff;
      prev_blue_in  = prev_blue_ff;
      rem_in        = rem_ff;
      fill_bit_in   = fill_bit_ff;
      word_in       = word_ff;
      srch_row_in   = srch_row_ff;
      srch_col_in   = srch_col_ff;
      srch_base_in  = srch_base_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      out_index_in  = out_index_ff;
      out_red_in    = out_red_ff;
      out_green_in  = out_green_ff;
      out_blue_in   = out_blue_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      out_count_in  = out_count_ff;
      new_brick     = 1'b0;

      if (csr_valid) begin
         max_voxels_in = csr_max_voxels;
      end

      case (state_ff)
         S_RUN: begin
            if (accept) begin
               if (run_sum > POS_W'(BRICK_LEN)) begin
                  rsp_valid_in  = 1'b1;
                  out_index_in  = '0;
                  out_red_in    = '0;
                  out_green_in  = '0;
                  out_blue_in   = '0;
                  out_status_in = ST_OVERFLOW;
                  out_last_in   = 1'b1;
                  out_count_in  = filled_ff;
                  new_brick     = 1'b1;
               end else if (run_len != '0) begin
                  run_pos_in  = CNT_W'(run_sum);
                  filled_in   = filled_add;
                  rem_in      = run_len;
                  fill_bit_in = run_bit;
                  end_scan_in = 1'b0;
                  state_in    = S_FILL;
                  if (run_sum == POS_W'(BRICK_LEN)) begin
                     if (filled_add > max_voxels_ff) begin
                        rsp_valid_in  = 1'b1;
                        out_index_in  = '0;
                        out_red_in    = '0;
                        out_green_in  = '0;
                        out_blue_in   = '0;
                        out_status_in = ST_CAPACITY;
                        out_last_in   = 1'b1;
                        out_count_in  = filled_add;
                     end else if (filled_add == '0) begin
                        rsp_valid_in  = 1'b1;
                        out_index_in  = '0;
                        out_red_in    = '0;
                        out_green_in  = '0;
                        out_blue_in   = '0;
                        out_status_in = ST_EMPTY;
                        out_last_in   = 1'b1;
                        out_count_in  = '0;
                     end else begin
                        end_scan_in = 1'b1;
                     end
                  end
               end
            end
         end
         S_FILL: begin
            word_in = word_new;
            if (fill_wrap) begin
               rem_in      = rem_ff - RUN_LEN_W'(space);
               fill_row_in = fill_row_ff + 1'b1;
               fill_col_in = '0;
            end else begin
               rem_in      = '0;
               fill_col_in = fill_col_ff + COL_W'(rem_ff);
            end
            if (!fill_wrap || (SPAN_W'(rem_ff) == space)) begin
               if (run_pos_ff == CNT_W'(BRICK_LEN)) begin
                  if (end_scan_ff) begin
                     srch_row_in  = '0;
                     srch_col_in  = '0;
                     srch_base_in = '0;
                     fill_row_in  = '0;
                     fill_col_in  = '0;
                     state_in     = S_SRCH_RD;
                  end else begin
                     new_brick = 1'b1;
                  end
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_SRCH_RD: begin
            state_in = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            if (find_found) begin
               srch_col_in = find_pos;
               state_in    = S_COLOR;
            end else if (srch_row_ff == ROW_W'(ROWS - 1)) begin
               new_brick = 1'b1;
            end else begin
               srch_row_in  = srch_row_ff + 1'b1;
               srch_col_in  = '0;
               srch_base_in = srch_base_ff + IDX_W'(BRICK_SIDE);
               state_in     = S_SRCH_RD;
            end
         end
         S_COLOR: begin
            if (accept) begin
               if (cbyte_ff != 2'd2) begin
                  pend_in  = {pend_ff[DATA_W-1:0], req_data_byte};
                  cbyte_in = cbyte_ff + 1'b1;
               end else begin
                  emitted_in    = emitted_ff + 1'b1;
                  prev_red_in   = red_sum;
                  prev_green_in = green_sum;
                  prev_blue_in  = blue_sum;
                  cbyte_in      = '0;
                  pend_in       = '0;
                  rsp_valid_in  = 1'b1;
                  out_index_in  = srch_base_ff + IDX_W'(srch_col_ff);
                  out_red_in    = red_sum;
                  out_green_in  = green_sum;
                  out_blue_in   = blue_sum;
                  out_status_in = ST_VOXEL;
                  out_last_in   = (emitted_ff + 1'b1) >= filled_ff;
                  out_count_in  = filled_ff;
                  if ((emitted_ff + 1'b1) >= filled_ff) begin
                     new_brick = 1'b1;
                  end else if (srch_col_ff == COL_W'(BRICK_SIDE - 1)) begin
                     if (srch_row_ff == ROW_W'(ROWS - 1)) begin
                        new_brick = 1'b1;
                     end else begin
                        srch_row_in  = srch_row_ff + 1'b1;
                        srch_col_in  = '0;
                        srch_base_in = srch_base_ff + IDX_W'(BRICK_SIDE);
                        state_in     = S_SRCH_RD;
                     end
                  end else begin
                     srch_col_in = srch_col_ff + 1'b1;
                     state_in    = S_SRCH_RD;
                  end
               end
            end
         end
         default: begin
            new_brick = 1'b1;
         end
      endcase

      if (new_brick) begin
         state_in      = S_RUN;
         run_pos_in    = '0;
         filled_in     = '0;
         emitted_in    = '0;
         fill_row_in   = '0;
         fill_col_in   = '0;
         end_scan_in   = 1'b0;
         cbyte_in      = '0;
         pend_in       = '0;
         prev_red_in   = '0;
         prev_green_in = '0;
         prev_blue_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_RUN;
         max_voxels_ff <= CNT_W'(BRICK_LEN);
         run_pos_ff    <= '0;
         filled_ff     <= '0;
         emitted_ff    <= '0;
         fill_row_ff   <= '0;
         fill_col_ff   <= '0;
         end_scan_ff   <= 1'b0;
         cbyte_ff      <= '0;
         prev_red_ff   <= '0;
         prev_green_ff <= '0;
         prev_blue_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_voxels_ff <= max_voxels_in;
         run_pos_ff    <= run_pos_in;
         filled_ff     <= filled_in;
         emitted_ff    <= emitted_in;
         fill_row_ff   <= fill_row_in;
         fill_col_ff   <= fill_col_in;
         end_scan_ff   <= end_scan_in;
         cbyte_ff      <= cbyte_in;
         prev_red_ff   <= prev_red_in;
         prev_green_ff <= prev_green_in;
         prev_blue_ff  <= prev_blue_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      fill_bit_ff   <= fill_bit_in;
      word_ff       <= word_in;
      srch_row_ff   <= srch_row_in;
      srch_col_ff   <= srch_col_in;
      srch_base_ff  <= srch_base_in;
      pend_ff       <= pend_in;
      out_index_ff  <= out_index_in;
      out_red_ff    <= out_red_in;
      out_green_ff  <= out_green_in;
      out_blue_ff   <= out_blue_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_voxel_index   = out_index_ff;
   assign rsp_red           = out_red_ff;
   assign rsp_green         = out_green_ff;
   assign rsp_blue          = out_blue_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_last_of_brick = out_last_ff;
   assign rsp_voxel_count   = out_count_ff;

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (out_status_ff != ST_VOXEL)) |-> out_last_ff)
      else $error("error or empty result without last_of_brick");

   a_color_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COLOR) |-> ((filled_ff != '0) && (emitted_ff < filled_ff)))
      else $error("color phase with no voxel left to color");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (run_pos_ff < CNT_W'(BRICK_LEN)))
      else $error("run position reached brick end without leaving run phase");

   a_voxel_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (out_status_ff == ST_VOXEL)) |->
      ((out_count_ff != '0) && (IDX_W'(out_index_ff) <= IDX_W'(BRICK_LEN - 1))))
      else $error("voxel result outside the brick or in an empty brick");

endmodule

// File: rtl/vbid_occ_mem.sv
// Occupancy store of the voxel brick intra decoder: one word per brick row.
// Synchronous memory, one write port and one read port with registered data.
// No dependencies.
module vbid_occ_mem #(
   parameter int WORD_W = 8,
   parameter int DEPTH  = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/vbid_row_find.sv
// Finds the lowest set bit of one occupancy row at or above a start column.
// Pure logic, used by the scan of the voxel brick intra decoder.
// No dependencies.
module vbid_row_find #(
   parameter int WIDTH = 8,
   localparam int POS_W = $clog2(WIDTH)
) (
   input  logic [WIDTH-1:0] word,
   input  logic [POS_W-1:0] from,
   output logic             found,
   output logic [POS_W-1:0] pos
);

   logic [WIDTH-1:0] masked;

   always_comb begin
      masked = '0;
      pos = '0;
      for (int i = 0; i < WIDTH; i++) begin
         masked[i] = word[i] && (POS_W'(i) >= from);
      end
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (masked[i]) begin
            pos = POS_W'(i);
         end
      end
      found = |masked;
   end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for voxel_brick_intra_decoder: run-length occupancy and delta colors.
// Predicts every result from its own decoder model and checks them in order at the result port.
// Depends on vbid_pkg and the decoder RTL only.
module tb_top;
   import vbid_pkg::*;

   localparam int BRICK_LEN   = BRICK_SIDE_DEF * BRICK_SIDE_DEF * BRICK_SIDE_DEF;
   localparam int IDX_W       = $clog2(BRICK_LEN);
   localparam int CNT_W       = $clog2(BRICK_LEN + 1);
   localparam int MAX_RUN     = (1 << RUN_LEN_W) - 1;
   localparam int MAX_IDLE    = 18;
   localparam int SETTLE      = 200;
   localparam int CYCLE_LIMIT = 2_000_000;

   typedef enum logic {MODE_RUNS, MODE_COLORS} decode_mode_type;

   typedef struct packed {
      logic [IDX_W-1:0]    voxel_index;
      logic [COLOR_W-1:0]  red;
      logic [COLOR_W-1:0]  green;
      logic [COLOR_W-1:0]  blue;
      logic [STATUS_W-1:0] status;
      logic                last_of_brick;
      logic [CNT_W-1:0]    voxel_count;
   } brick_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [DATA_W-1:0]   req_data_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [IDX_W-1:0]    rsp_voxel_index;
   logic [COLOR_W-1:0]  rsp_red;
   logic [COLOR_W-1:0]  rsp_green;
   logic [COLOR_W-1:0]  rsp_blue;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last_of_brick;
   logic [CNT_W-1:0]    rsp_voxel_count;
   logic                csr_valid;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_max_voxels;

   // Decoder model state.
   bit              occ_map [BRICK_LEN];
   decode_mode_type mode;
   int              run_pos;
   int              fill_cnt;
   int              scan_pos;
   int              emit_cnt;
   int              color_bytes;
   logic [23:0]     prev_rgb;
   logic [15:0]     pend_rg;
   int              cap_max;

   brick_result_type brick_results[$];
   int               error_count = 0;
   int               sent_items = 0;
   int               cycle_count = 0;
   bit               idle_on = 1'b1;

   voxel_brick_intra_decoder u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_voxel_index   (rsp_voxel_index),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_status        (rsp_status),
      .rsp_last_of_brick (rsp_last_of_brick),
      .rsp_voxel_count   (rsp_voxel_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_voxels    (csr_max_voxels)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int min_int(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   function automatic void start_brick();
      mode        = MODE_RUNS;
      run_pos     = 0;
      fill_cnt    = 0;
      scan_pos    = 0;
      emit_cnt    = 0;
      color_bytes = 0;
      prev_rgb    = '0;
      pend_rg     = '0;
   endfunction

   function automatic int next_set(input int from);
      int p;
      p = from;
      while (p < BRICK_LEN && !occ_map[p]) p++;
      return p;
   endfunction

   function automatic void decode_stream_byte(input logic [DATA_W-1:0] data,
                                              output bit produced,
                                              output brick_result_type res);
      int               len;
      int               nxt;
      int               k;
      bit               fill;
      logic [COLOR_W-1:0] r;
      logic [COLOR_W-1:0] g;
      logic [COLOR_W-1:0] bl;
      produced = 1'b0;
      res      = '0;
      if (mode == MODE_RUNS) begin
         len  = int'(data[RUN_LEN_W-1:0]);
         fill = data[RUN_FILLED_BIT];
         if (run_pos + len > BRICK_LEN) begin
            res.status        = ST_OVERFLOW;
            res.last_of_brick = 1'b1;
            res.voxel_count   = CNT_W'(fill_cnt);
            produced          = 1'b1;
            start_brick();
            return;
         end
         for (k = 0; k < len; k++) occ_map[run_pos + k] = fill;
         run_pos += len;
         if (fill) fill_cnt += len;
         if (run_pos < BRICK_LEN) return;
         if (fill_cnt > cap_max) begin
            res.status        = ST_CAPACITY;
            res.last_of_brick = 1'b1;
            res.voxel_count   = CNT_W'(fill_cnt);
            produced          = 1'b1;
            start_brick();
         end else if (fill_cnt == 0) begin
            res.status        = ST_EMPTY;
            res.last_of_brick = 1'b1;
            produced          = 1'b1;
            start_brick();
         end else begin
            mode        = MODE_COLORS;
            scan_pos    = next_set(0);
            color_bytes = 0;
            pend_rg     = '0;
         end
         return;
      end
      if (color_bytes < 2) begin
         pend_rg = {pend_rg[7:0], data};
         color_bytes++;
         return;
      end
      r        = prev_rgb[23:16] + pend_rg[15:8];
      g        = prev_rgb[15:8] + pend_rg[7:0];
      bl       = prev_rgb[7:0] + data;
      prev_rgb = {r, g, bl};
      emit_cnt++;
      res.voxel_index   = IDX_W'(scan_pos);
      res.red           = r;
      res.green         = g;
      res.blue          = bl;
      res.status        = ST_VOXEL;
      res.last_of_brick = (emit_cnt >= fill_cnt);
      res.voxel_count   = CNT_W'(fill_cnt);
      produced          = 1'b1;
      color_bytes       = 0;
      pend_rg           = '0;
      if (res.last_of_brick) begin
         start_brick();
      end else begin
         nxt = next_set(scan_pos + 1);
         if (nxt >= BRICK_LEN) start_brick();
         else scan_pos = nxt;
      end
   endfunction

   task automatic send_byte(input logic [DATA_W-1:0] data);
      int               gap;
      bit               produced;
      brick_result_type res;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      decode_stream_byte(data, produced, res);
      if (produced) brick_results.push_back(res);
      sent_items++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (brick_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_max_voxels(input int value);
      drain();
      csr_valid      <= 1'b1;
      csr_max_voxels <= CNT_W'(value);
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      cap_max = value;
   endtask

   // Brings the decoder back to the start of a brick, mostly through a run overflow.
   task automatic resync_brick();
      int rem;
      while (!(mode == MODE_RUNS && run_pos == 0)) begin
         if (mode == MODE_RUNS) begin
            rem = BRICK_LEN - run_pos;
            if (rem < MAX_RUN) send_byte({1'($urandom_range(0, 1)), 7'(MAX_RUN)});
            else send_byte(8'(min_int(MAX_RUN, rem - 1)));
         end else begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic send_colors();
      while (mode == MODE_COLORS) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic send_sparse_brick(input int fill_pct);
      int rem;
      int len;
      while (run_pos < BRICK_LEN && mode == MODE_RUNS) begin
         rem = BRICK_LEN - run_pos;
         if ($urandom_range(0, 99) < 3) begin
            send_byte({1'($urandom_range(0, 1)), 7'd0});
         end else if ($urandom_range(0, 99) < fill_pct) begin
            len = $urandom_range(1, min_int(4, rem));
            send_byte({1'b1, 7'(len)});
         end else begin
            len = $urandom_range(1, min_int(MAX_RUN, rem));
            send_byte({1'b0, 7'(len)});
         end
         if (run_pos == 0) break;
      end
      send_colors();
   endtask

   task automatic send_overshoot_brick();
      int rem;
      int len;
      rem = BRICK_LEN - run_pos;
      while (rem >= MAX_RUN) begin
         len = $urandom_range(1, min_int(MAX_RUN, rem - 1));
         send_byte({1'($urandom_range(0, 99) < 30), 7'(len)});
         rem = BRICK_LEN - run_pos;
      end
      send_byte({1'($urandom_range(0, 1)), 7'($urandom_range(rem + 1, MAX_RUN))});
   endtask

   task automatic send_full_brick();
      repeat (4) send_byte(8'hFF);
      send_byte({1'b1, 7'(BRICK_LEN - 4 * MAX_RUN)});
   endtask

   task automatic send_empty_brick();
      int rem;
      while (run_pos < BRICK_LEN && mode == MODE_RUNS) begin
         rem = BRICK_LEN - run_pos;
         if ($urandom_range(0, 1)) send_byte(8'(min_int(MAX_RUN, rem)));
         else send_byte(8'($urandom_range(0, min_int(MAX_RUN, rem))));
         if (run_pos == 0) break;
      end
   endtask

   task automatic test_zero_and_empty();
      send_byte(8'h00);
      send_byte(8'h80);
      repeat (4) send_byte(8'h7F);
      send_byte(8'h04);
   endtask

   task automatic test_run_overflow();
      repeat (4) send_byte(8'hFF);
      send_byte(8'h85);
   endtask

   task automatic test_capacity_limit();
      set_max_voxels(0);
      send_byte(8'h81);
      repeat (4) send_byte(8'h7F);
      send_byte(8'h03);
      set_max_voxels(BRICK_LEN);
   endtask

   task automatic test_last_voxel_color();
      repeat (4) send_byte(8'h7F);
      send_byte(8'h03);
      send_byte(8'h81);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h80);
   endtask

   task automatic test_random_bricks(input int cap, input int items);
      int stop_at;
      int pick;
      set_max_voxels(cap);
      stop_at = sent_items + items;
      while (sent_items < stop_at) begin
         idle_on = ($urandom_range(0, 3) != 0);
         pick    = $urandom_range(0, 99);
         if (pick < 12) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            resync_brick();
            if (pick < 24) send_overshoot_brick();
            else if (pick < 30 && cap_max < BRICK_LEN) send_full_brick();
            else if (pick < 35) send_empty_brick();
            else send_sparse_brick($urandom_range(3, 40));
         end
      end
      resync_brick();
      idle_on = 1'b1;
   endtask

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= 10)
            $display("Mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endtask

   initial begin : result_side
      int               stall;
      brick_result_type got;
      brick_result_type want;
      forever begin
         stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1 || reset) @(posedge clock);
         got = {rsp_voxel_index, rsp_red, rsp_green, rsp_blue, rsp_status,
                rsp_last_of_brick, rsp_voxel_count};
         if (brick_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("Result with no prediction pending: status %0d index %0d",
                        got.status, got.voxel_index);
         end else begin
            want = brick_results.pop_front();
            report_field("voxel_index", 32'(want.voxel_index), 32'(got.voxel_index));
            report_field("red", 32'(want.red), 32'(got.red));
            report_field("green", 32'(want.green), 32'(got.green));
            report_field("blue", 32'(want.blue), 32'(got.blue));
            report_field("status", 32'(want.status), 32'(got.status));
            report_field("last_of_brick", 32'(want.last_of_brick),
                         32'(got.last_of_brick));
            report_field("voxel_count", 32'(want.voxel_count), 32'(got.voxel_count));
         end
      end
   end

   initial begin : stimulus
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data_byte  <= '0;
      csr_valid      <= 1'b0;
      csr_max_voxels <= '0;
      cap_max = BRICK_LEN;
      start_brick();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_zero_and_empty();
      test_run_overflow();
      test_capacity_limit();
      test_last_voxel_color();

      test_random_bricks(BRICK_LEN, 400);
      test_random_bricks(0, 150);
      test_random_bricks(1, 150);
      test_random_bricks(BRICK_LEN - 1, 200);
      test_random_bricks($urandom_range(2, BRICK_LEN - 2), 200);
      test_random_bricks($urandom_range(2, BRICK_LEN - 2), 200);

      drain();
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
